[hw/rtl/psg_channel_event_recorder_macros.svh]
// Assertion macros shared by the channel event recorder RTL.
`ifndef PSG_CHANNEL_EVENT_RECORDER_MACROS_SVH
`define PSG_CHANNEL_EVENT_RECORDER_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define PSG_CER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define PSG_CER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/psg_cer_pkg.sv]
// Types, constants and the note lookup for the channel event recorder.
package psg_cer_pkg;

    localparam int CH_SLOTS         = 4;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int NUM_TONE_CH      = 3;
    localparam int NOTE_ROM_LEN     = 97;
    localparam int S_TDATA_W        = 56;
    localparam int M_TDATA_W        = 96;

    localparam logic [3:0] MUTE_ATT = 4'hf;

    localparam logic [11:0] DIV_ROM [NOTE_ROM_LEN] = '{
        12'h6ae, 12'h64e, 12'h5f4, 12'h59e, 12'h54e, 12'h502, 12'h4ba, 12'h476,
        12'h436, 12'h3f8, 12'h3c0, 12'h38a, 12'h357, 12'h327, 12'h2fa, 12'h2cf,
        12'h2a7, 12'h281, 12'h25d, 12'h23b, 12'h21b, 12'h1fc, 12'h1e0, 12'h1c5,
        12'h1ac, 12'h194, 12'h17d, 12'h168, 12'h153, 12'h140, 12'h12e, 12'h11d,
        12'h10d, 12'h0fe, 12'h0f0, 12'h0e3, 12'h0d6, 12'h0ca, 12'h0be, 12'h0b4,
        12'h0aa, 12'h0a0, 12'h097, 12'h08f, 12'h087, 12'h07f, 12'h078, 12'h071,
        12'h06b, 12'h065, 12'h05f, 12'h05a, 12'h055, 12'h050, 12'h04c, 12'h047,
        12'h043, 12'h040, 12'h03c, 12'h039, 12'h035, 12'h032, 12'h030, 12'h02d,
        12'h02a, 12'h028, 12'h026, 12'h024, 12'h022, 12'h020, 12'h01e, 12'h01c,
        12'h01b, 12'h019, 12'h018, 12'h016, 12'h015, 12'h014, 12'h013, 12'h012,
        12'h011, 12'h010, 12'h00f, 12'h00e, 12'h00d, 12'h00d, 12'h00c, 12'h00b,
        12'h00b, 12'h00a, 12'h009, 12'h008, 12'h007, 12'h006, 12'h005, 12'h004,
        12'h000
    };

    // One open record as held in the record memory.
    typedef struct packed {
        logic [11:0] divider;
        logic [3:0]  attenuation;
        logic [6:0]  note;
        logic [31:0] start;
        logic [31:0] stop;
    } rec_t;

    // One result request.
    typedef struct packed {
        logic [1:0]  rec_channel;
        logic [11:0] rec_divider;
        logic [6:0]  rec_note;
        logic [3:0]  rec_attenuation;
        logic [31:0] rec_start;
        logic [31:0] rec_duration;
        logic        rec_last;
    } out_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FL_PICK,
        ST_FL_EMIT
    } state_t;

    // Ranges of the table are disjoint, so at most one comparator pair fires.
    function automatic logic [6:0] note_of(input logic [11:0] div);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < NOTE_ROM_LEN - 1; i++) begin
            if (div >= DIV_ROM[i+1] && div < DIV_ROM[i]) begin
                n = n | 7'(i);
            end
        end
        return n;
    endfunction

endpackage

[hw/rtl/psg_cer_rec_mem.sv]
// Per-channel open record memory, one write and one registered read port.
module psg_cer_rec_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  psg_cer_pkg::rec_t   wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output psg_cer_pkg::rec_t   rdata_reg
);
    import psg_cer_pkg::*;

    rec_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read-before-write: a same-address collision returns the old word
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

[hw/rtl/psg_cer_out_fifo.sv]
// Two-entry result buffer between the record logic and the master port.
module psg_cer_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  psg_cer_pkg::out_t  push_data,
    output logic               full,
    output logic               m_valid,
    input  logic               m_ready,
    output psg_cer_pkg::out_t  m_data
);
    import psg_cer_pkg::*;

    out_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/psg_channel_event_recorder.sv]
// Top level of the sound-chip channel event recorder.
//
// Slave channel (s_*): one request per channel write or flush. s_tuser is
// the kind (0 write, 1 flush); s_tdata carries channel, divider,
// attenuation and frame time. Master channel (m_*): one request per closed
// record, m_tlast marks the final record caused by one input request.
// Open records live in a small synchronous memory, one word per channel;
// valid bits sit in flops. A write reads its channel's word in the accept
// cycle; the update stage changes it and writes it back once it advances,
// and a bypass register covers a write-back colliding with the following
// read of the same word. Throughput: one write request per cycle while the
// result buffer has room. A result is registered in the update stage and
// in the result buffer before it shows on m_tvalid. A flush holds s_tready
// low while each open record is read on the single port, then emitted.
// Writes to channels beyond the configured count are dropped silently.
// Reset (aresetn low, synchronous) clears all valid bits, the pipeline
// and the result buffer; memory contents are left as they are.
// When m_tready is low, up to two results wait in the buffer and the
// update stage holds, which then stalls s_tready.
module psg_channel_event_recorder #(
    parameter int NUM_CHANNELS = psg_cer_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] channel, [13:2] divider, [17:14] attenuation, [49:18] frame_time
    input  logic [psg_cer_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] rec_channel, [13:2] rec_divider, [20:14] rec_note,
    // [24:21] rec_attenuation, [56:25] rec_start, [88:57] rec_duration
    output logic [psg_cer_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast
);
    import psg_cer_pkg::*;

    // configured channels, capped at what the 2-bit field can address
    localparam int EFF  = (NUM_CHANNELS < CH_SLOTS) ? NUM_CHANNELS : CH_SLOTS;
    localparam int CH_W = (EFF > 1) ? $clog2(EFF) : 1;

    // input decode
    logic [1:0]  in_ch;
    logic [11:0] in_div;
    logic [3:0]  in_att;
    logic [31:0] in_time;
    logic [11:0] in_div_eff;
    logic [6:0]  in_note;
    logic        in_ok;
    logic        accept;

    assign in_ch   = s_tdata[1:0];
    assign in_div  = s_tdata[13:2];
    assign in_att  = s_tdata[17:14];
    assign in_time = s_tdata[49:18];
    assign accept  = s_tvalid && s_tready;

    always_comb begin
        in_div_eff = (in_att == MUTE_ATT) ? 12'd0 : in_div;
        in_ok      = (int'(in_ch) < EFF);
        in_note    = (int'(in_ch) < NUM_TONE_CH && in_div_eff != 12'd0)
                     ? note_of(in_div_eff) : 7'd0;
    end

    // update stage
    logic            s1_valid_reg, s1_valid_next;
    logic [CH_W-1:0] s1_ch_reg;
    logic [11:0]     s1_div_reg;
    logic [3:0]      s1_att_reg;
    logic [6:0]      s1_note_reg;
    logic [31:0]     s1_time_reg;

    logic            byp_hit_reg, byp_hit_next;
    rec_t            byp_reg;

    logic [EFF-1:0]  valid_reg, valid_next;
    state_t          state_reg, state_next;
    logic [CH_W-1:0] fl_ch_reg, fl_ch_next;

    // memory ports
    logic            mem_we;
    rec_t            mem_wdata;
    logic            mem_re;
    logic [CH_W-1:0] mem_raddr;
    rec_t            mem_rdata;

    // result buffer
    logic            fifo_full;
    logic            push;
    out_t            push_data;
    out_t            m_data;

    // s1 decision
    logic            s1_adv;
    rec_t            old_rec;
    rec_t            new_rec;
    rec_t            ext_rec;
    logic            s1_vld;
    logic            s1_emit;
    rec_t            s1_emit_rec;

    // flush pick
    logic            pick_any;
    logic [CH_W-1:0] pick_ch;
    logic [EFF-1:0]  fl_mask;

    assign s_tready = (state_reg == ST_RUN) && (!s1_valid_reg || !fifo_full);
    assign s1_adv   = s1_valid_reg && !fifo_full;

    always_comb begin
        old_rec = byp_hit_reg ? byp_reg : mem_rdata;
        s1_vld  = valid_reg[s1_ch_reg];

        new_rec.divider     = s1_div_reg;
        new_rec.attenuation = s1_att_reg;
        new_rec.note        = s1_note_reg;
        new_rec.start       = s1_time_reg;
        new_rec.stop        = s1_time_reg;

        ext_rec      = old_rec;
        ext_rec.stop = s1_time_reg;

        s1_emit     = 1'b0;
        s1_emit_rec = ext_rec;
        mem_wdata   = new_rec;
        if (!s1_vld) begin
            mem_wdata = new_rec;
        end else if (s1_att_reg == MUTE_ATT) begin
            if (old_rec.attenuation == MUTE_ATT) begin
                mem_wdata = ext_rec;
            end else begin
                // mute after sound: old end time stays
                s1_emit     = 1'b1;
                s1_emit_rec = old_rec;
                mem_wdata   = new_rec;
            end
        end else if (s1_div_reg != old_rec.divider
                     || s1_att_reg != old_rec.attenuation) begin
            s1_emit   = 1'b1;
            mem_wdata = new_rec;
        end else begin
            mem_wdata = ext_rec;
        end
    end

    assign mem_we = s1_adv;

    // lowest open channel for the flush sweep
    always_comb begin
        pick_any = 1'b0;
        pick_ch  = '0;
        for (int i = 0; i < EFF; i++) begin
            if (valid_reg[i] && !pick_any) begin
                pick_any = 1'b1;
                pick_ch  = CH_W'(i);
            end
        end
        fl_mask            = '0;
        fl_mask[fl_ch_reg] = 1'b1;
    end

    // sequencer: read port select, result mux, valid bits
    always_comb begin
        state_next    = state_reg;
        fl_ch_next    = fl_ch_reg;
        valid_next    = valid_reg;
        s1_valid_next = s1_valid_reg;
        mem_re        = 1'b0;
        mem_raddr     = in_ch[CH_W-1:0];
        byp_hit_next  = byp_hit_reg;
        push          = 1'b0;

        push_data.rec_channel     = 2'(s1_ch_reg);
        push_data.rec_divider     = s1_emit_rec.divider;
        push_data.rec_note        = s1_emit_rec.note;
        push_data.rec_attenuation = s1_emit_rec.attenuation;
        push_data.rec_start       = s1_emit_rec.start;
        push_data.rec_duration    = s1_emit_rec.stop - s1_emit_rec.start;
        push_data.rec_last        = 1'b1;

        case (state_reg)
            ST_RUN: begin
                if (s1_adv) begin
                    valid_next[s1_ch_reg] = 1'b1;
                    push                  = s1_emit;
                    s1_valid_next         = 1'b0;
                end
                if (accept) begin
                    if (s_tuser) begin
                        state_next = ST_FL_PICK;
                    end else if (in_ok) begin
                        s1_valid_next = 1'b1;
                        mem_re        = 1'b1;
                        byp_hit_next  = mem_we && (s1_ch_reg == in_ch[CH_W-1:0]);
                    end
                end
            end
            ST_FL_PICK: begin
                if (pick_any) begin
                    mem_re       = 1'b1;
                    mem_raddr    = pick_ch;
                    byp_hit_next = 1'b0;
                    fl_ch_next   = pick_ch;
                    state_next   = ST_FL_EMIT;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_FL_EMIT: begin
                push_data.rec_channel     = 2'(fl_ch_reg);
                push_data.rec_divider     = mem_rdata.divider;
                push_data.rec_note        = mem_rdata.note;
                push_data.rec_attenuation = mem_rdata.attenuation;
                push_data.rec_start       = mem_rdata.start;
                push_data.rec_duration    = mem_rdata.stop - mem_rdata.start;
                push_data.rec_last        = ((valid_reg & ~fl_mask) == '0);
                if (!fifo_full) begin
                    push                  = 1'b1;
                    valid_next[fl_ch_reg] = 1'b0;
                    state_next            = ST_FL_PICK;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            s1_valid_reg <= 1'b0;
            valid_reg    <= '0;
            byp_hit_reg  <= 1'b0;
            fl_ch_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            valid_reg    <= valid_next;
            byp_hit_reg  <= byp_hit_next;
            fl_ch_reg    <= fl_ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tuser && in_ok) begin
            s1_ch_reg   <= in_ch[CH_W-1:0];
            s1_div_reg  <= in_div_eff;
            s1_att_reg  <= in_att;
            s1_note_reg <= in_note;
            s1_time_reg <= in_time;
        end
        if (mem_we) begin
            byp_reg <= mem_wdata;
        end
    end

    psg_cer_rec_mem #(
        .DEPTH (EFF),
        .AW    (CH_W)
    ) u_rec_mem (
        .aclk      (aclk),
        .we        (mem_we),
        .waddr     (s1_ch_reg),
        .wdata     (mem_wdata),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

    psg_cer_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_data)
    );

    assign m_tdata = {7'd0,
                      m_data.rec_duration,
                      m_data.rec_start,
                      m_data.rec_attenuation,
                      m_data.rec_note,
                      m_data.rec_divider,
                      m_data.rec_channel};
    assign m_tlast = m_data.rec_last;

    `include "psg_channel_event_recorder_macros.svh"

    `PSG_CER_ASSERT_NOW(a_push_room, push, !fifo_full, "result pushed into full buffer")
    `PSG_CER_ASSERT_NOW(a_no_wr_flush, state_reg != ST_RUN, !mem_we, "record write during flush")
    `PSG_CER_ASSERT_NEXT(a_flush_clear, state_reg == ST_FL_EMIT && push,
        !valid_reg[$past(fl_ch_reg)], "flushed record still open")
    `PSG_CER_ASSERT_NOW(a_write_last, state_reg == ST_RUN && push, push_data.rec_last,
        "write result without last flag")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the sound-chip channel event recorder.
module testbench;
    import psg_cer_pkg::*;

    // Tracks the open record of every channel and the closed records the block owes.
    class record_ledger;
        out_t        owed_records[$];
        bit          live       [CH_SLOTS];
        logic [11:0] held_div   [CH_SLOTS];
        logic [3:0]  held_att   [CH_SLOTS];
        logic [6:0]  held_note  [CH_SLOTS];
        logic [31:0] held_start [CH_SLOTS];
        logic [31:0] held_stop  [CH_SLOTS];
        int          faults;
        int          matched;

        function new();
            for (int i = 0; i < CH_SLOTS; i++) begin
                live[i]       = 1'b0;
                held_div[i]   = '0;
                held_att[i]   = '0;
                held_note[i]  = '0;
                held_start[i] = '0;
                held_stop[i]  = '0;
            end
            faults  = 0;
            matched = 0;
        endfunction

        // First range of the descending table that holds the divider; none gives 0.
        function logic [6:0] note_for(logic [11:0] div);
            for (int i = 0; i < NOTE_ROM_LEN - 1; i++) begin
                if (div >= DIV_ROM[i+1] && div < DIV_ROM[i]) begin
                    return 7'(i);
                end
            end
            return 7'd0;
        endfunction

        function void open_slot(int ch, logic [11:0] div, logic [3:0] att, logic [31:0] t);
            live[ch]       = 1'b1;
            held_div[ch]   = div;
            held_att[ch]   = att;
            held_note[ch]  = (ch < NUM_TONE_CH && div != '0) ? note_for(div) : 7'd0;
            held_start[ch] = t;
            held_stop[ch]  = t;
        endfunction

        function out_t closed(int ch);
            out_t r;
            r.rec_channel     = 2'(ch);
            r.rec_divider     = held_div[ch];
            r.rec_note        = held_note[ch];
            r.rec_attenuation = held_att[ch];
            r.rec_start       = held_start[ch];
            r.rec_duration    = held_stop[ch] - held_start[ch];
            r.rec_last        = 1'b0;
            return r;
        endfunction

        // Called for each accepted input request.
        function void take_request(bit kind, logic [1:0] ch, logic [11:0] div,
                                   logic [3:0] att, logic [31:0] t);
            out_t batch [CH_SLOTS];
            int   n;
            n = 0;
            if (kind) begin
                for (int i = 0; i < CH_SLOTS; i++) begin
                    if (live[i]) begin
                        batch[n] = closed(i);
                        n++;
                        live[i] = 1'b0;
                    end
                end
            end else begin
                if (att == MUTE_ATT) div = '0;
                if (!live[ch]) begin
                    open_slot(ch, div, att, t);
                end else if (att == MUTE_ATT) begin
                    if (held_att[ch] == MUTE_ATT) begin
                        held_stop[ch] = t;
                    end else begin
                        // mute after sound: old record keeps its end time
                        batch[n] = closed(ch);
                        n++;
                        open_slot(ch, div, att, t);
                    end
                end else if (div != held_div[ch] || att != held_att[ch]) begin
                    held_stop[ch] = t;
                    batch[n] = closed(ch);
                    n++;
                    open_slot(ch, div, att, t);
                end else begin
                    held_stop[ch] = t;
                end
            end
            if (n > 0) batch[n-1].rec_last = 1'b1;
            for (int i = 0; i < n; i++) owed_records = {owed_records, batch[i]};
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: record %0d %s expected 0x%0h got 0x%0h",
                         $time, matched, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // Called for each accepted result request.
        function void check_record(logic [M_TDATA_W-1:0] data, logic last);
            out_t want;
            bit   ok;
            if (owed_records.size() == 0) begin
                $display("%0t: record with none expected, expected nothing got tdata 0x%0h last %b",
                         $time, data, last);
                faults++;
                return;
            end
            want = owed_records.pop_front();
            ok = 1'b1;
            ok &= field_ok("rec_channel", 32'(want.rec_channel), 32'(data[1:0]));
            ok &= field_ok("rec_divider", 32'(want.rec_divider), 32'(data[13:2]));
            ok &= field_ok("rec_note", 32'(want.rec_note), 32'(data[20:14]));
            ok &= field_ok("rec_attenuation", 32'(want.rec_attenuation), 32'(data[24:21]));
            ok &= field_ok("rec_start", want.rec_start, data[56:25]);
            ok &= field_ok("rec_duration", want.rec_duration, data[88:57]);
            ok &= field_ok("rec_last", 32'(want.rec_last), 32'(last));
            if (!ok) faults++;
            matched++;
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    record_ledger ledger;
    logic [11:0]  last_div [CH_SLOTS];
    logic [3:0]   last_att [CH_SLOTS];
    logic [31:0]  frame_now = '0;
    int           n_writes  = 0;
    int           n_flushes = 0;

    psg_channel_event_recorder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_record(m_tdata, m_tlast);
    end

    // Presents one request and returns at the edge it is taken; tvalid stays high.
    task automatic send_request(bit kind, logic [1:0] ch, logic [11:0] div,
                                logic [3:0] att, logic [31:0] t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        // 6 pad bits above channel, divider, attenuation and frame time
        s_tdata  <= {6'd0, t, att, div, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.take_request(kind, ch, div, att, t);
        if (kind) begin
            n_flushes++;
        end else begin
            n_writes++;
            last_div[ch] = div;
            last_att[ch] = att;
        end
    endtask

    // Hold off the sender until every owed record has been seen.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ledger.owed_records.size() != 0);
    endtask

    // Mostly plausible writes, rare flushes: repeats, table edges, mutes, rising frames.
    task automatic random_request();
        logic [1:0]  ch;
        logic [11:0] div;
        logic [3:0]  att;
        int          pick;
        ch = 2'($urandom_range(3));
        if ($urandom_range(99) < 6) begin
            send_request(1'b1, ch, 12'($urandom), 4'($urandom), $urandom);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 45)      div = last_div[ch];
        else if (pick < 65) div = DIV_ROM[$urandom_range(NOTE_ROM_LEN - 1)] - 12'($urandom_range(1));
        else                div = 12'($urandom);
        pick = $urandom_range(99);
        if (pick < 20)      att = MUTE_ATT;
        else if (pick < 60) att = last_att[ch];
        else                att = 4'($urandom_range(15));
        if ($urandom_range(99) < 90) frame_now = frame_now + 32'($urandom_range(400));
        else                         frame_now = $urandom;
        send_request(1'b0, ch, div, att, frame_now);
    endtask

    initial begin
        ledger = new();
        for (int i = 0; i < CH_SLOTS; i++) begin
            last_div[i] = '0;
            last_att[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: table edges, repeats, mutes, noise, wrap-around and flushes
        send_request(1'b0, 2'd0, 12'h6ae, 4'd0, 32'd0);           // top entry, no range
        send_request(1'b0, 2'd0, 12'h6ae, 4'd0, 32'd5);           // repeat extends
        send_request(1'b0, 2'd0, 12'h6ad, 4'd0, 32'd9);           // change closes
        send_request(1'b0, 2'd0, 12'hfff, 4'd0, 32'd12);          // above the table
        send_request(1'b0, 2'd1, 12'h004, 4'd3, 32'hffff_fff0);   // lowest non-zero entry
        send_request(1'b0, 2'd1, 12'h003, 4'd3, 32'h0000_0010);   // duration wraps
        send_request(1'b0, 2'd1, 12'h000, 4'd3, 32'd20);          // zero divider on tone
        send_request(1'b0, 2'd2, 12'h123, MUTE_ATT, 32'd30);      // first write muted
        send_request(1'b0, 2'd2, 12'habc, MUTE_ATT, 32'd40);      // repeated mute
        send_request(1'b0, 2'd2, 12'h00d, 4'd0, 32'd50);          // duplicate table value
        send_request(1'b0, 2'd2, 12'h00d, 4'd0, 32'd55);
        send_request(1'b0, 2'd2, 12'h555, MUTE_ATT, 32'd60);      // mute after sound
        send_request(1'b0, 2'd3, 12'h100, 4'd5, 32'd70);          // noise channel
        send_request(1'b0, 2'd3, 12'h100, 4'd6, 32'd80);          // attenuation change only
        send_request(1'b0, 2'd3, 12'hfff, 4'd14, 32'd90);
        send_request(1'b1, 2'd3, 12'hfff, MUTE_ATT, 32'hffff_ffff); // flush of all four
        send_request(1'b1, 2'd0, 12'h000, 4'd0, 32'd0);           // empty flush
        send_request(1'b0, 2'd0, 12'hfff, 4'd14, 32'hffff_ffff);
        send_request(1'b0, 2'd0, 12'hfff, 4'd14, 32'd0);
        send_request(1'b0, 2'd0, 12'h07f, 4'd1, 32'd1);
        send_request(1'b0, 2'd1, 12'h00b, 4'd0, 32'd2);
        send_request(1'b0, 2'd1, 12'h00c, 4'd0, 32'd3);
        send_request(1'b1, 2'd2, 12'h5a5, 4'd10, 32'h5a5a_5a5a);
        wait_drained();

        // three idling mixes, a full drain between them
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 23 : 0;
            repeat (145) random_request();
            wait_drained();
        end
        send_request(1'b1, 2'd0, 12'h000, 4'd0, 32'd0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (ledger.owed_records.size() != 0) begin
            $display("%0t: %0d records never arrived", $time, ledger.owed_records.size());
            ledger.faults++;
        end
        $display("Covered %0d channel writes and %0d flushes under three idling mixes;",
                 n_writes, n_flushes);
        $display("%0d closed records compared field by field.", ledger.matched);
        if (ledger.faults == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout: the recorder stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
